// ----- rtl/tkd_pkg.sv -----
`timescale 1ns / 1ps

package tkd_pkg;

    // key_mod flag bits
    localparam logic [5:0] MOD_BTN     = 6'b000001;
    localparam logic [5:0] MOD_TIMEOUT = 6'b000010;
    localparam logic [5:0] MOD_CTRL    = 6'b000100;
    localparam logic [5:0] MOD_ALT     = 6'b001000;
    localparam logic [5:0] MOD_CHAR    = 6'b010000;
    localparam logic [5:0] MOD_FN      = 6'b100000;
    localparam logic [5:0] MOD_TMO_KEY = MOD_BTN | MOD_TIMEOUT;
    localparam logic [5:0] MOD_REPEAT  = MOD_CTRL | MOD_ALT | MOD_FN;

    // button codes
    localparam logic [4:0] BTN_NONE      = 5'd0;
    localparam logic [4:0] BTN_ENTER     = 5'd1;
    localparam logic [4:0] BTN_BACKSPACE = 5'd2;
    localparam logic [4:0] BTN_ESC       = 5'd3;
    localparam logic [4:0] BTN_UP        = 5'd4;
    localparam logic [4:0] BTN_DOWN      = 5'd5;
    localparam logic [4:0] BTN_RIGHT     = 5'd6;
    localparam logic [4:0] BTN_LEFT      = 5'd7;
    localparam logic [4:0] BTN_HOME      = 5'd8;
    localparam logic [4:0] BTN_END       = 5'd9;
    localparam logic [4:0] BTN_PGUP      = 5'd10;
    localparam logic [4:0] BTN_PGDN      = 5'd11;
    localparam logic [4:0] BTN_MOD_BASE  = 5'd12;

    // byte values
    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_DEL    = 8'd127;
    localparam logic [7:0] CH_ESC    = 8'd27;
    localparam logic [7:0] CH_CSI    = 8'd91;
    localparam logic [7:0] CH_TILDE  = 8'd126;
    localparam logic [7:0] CH_ONE    = 8'd49;
    localparam logic [7:0] CH_SEMI   = 8'd59;
    localparam logic [7:0] CH_FIVE   = 8'd53;
    localparam logic [7:0] CH_SIX    = 8'd54;
    localparam logic [7:0] CH_TWO    = 8'd50;
    localparam logic [7:0] CH_UP_H   = 8'd72;
    localparam logic [7:0] CH_UP_F   = 8'd70;
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_UP_A   = 8'd65;
    localparam logic [7:0] CH_UP_B   = 8'd66;
    localparam logic [7:0] CH_UP_C   = 8'd67;
    localparam logic [7:0] CH_UP_D   = 8'd68;
    localparam logic [7:0] CTRL_BIAS = 8'd96;

    typedef struct packed {
        logic       ok;
        logic [5:0] mod;
        logic [7:0] chr;
        logic       set_btn;
        logic [4:0] btn;
    } dec_t;

    typedef struct packed {
        logic       ok;
        logic [5:0] key_mod;
        logic [7:0] key_char;
        logic [4:0] key_button;
        logic [3:0] repeat_count;
        logic       committed;
        logic       is_timeout;
        logic       is_text_key;
        logic       is_backspace;
    } res_t;

endpackage

// ----- rtl/tkd_decode.sv -----
`timescale 1ns / 1ps

module tkd_decode
(
    input  logic [2:0]    byte_count,
    input  logic [7:0]    byte0,
    input  logic [7:0]    byte1,
    input  logic [7:0]    byte2,
    input  logic [7:0]    byte3,
    input  logic [7:0]    byte4,
    input  logic [7:0]    byte5,
    output tkd_pkg::dec_t dec
);
    import tkd_pkg::*;

    logic       csi;
    logic [1:0] dir;
    logic [2:0] digit;

    assign csi   = (byte0 == CH_ESC) && (byte1 == CH_CSI);
    assign dir   = byte5[1:0] - CH_UP_A[1:0];
    assign digit = byte4[2:0] - CH_TWO[2:0];

    always_comb
    begin
        dec         = '0;
        dec.ok      = 1'b1;
        unique case (byte_count)
            3'd0:
            begin
                dec.set_btn = 1'b1;
                dec.btn     = BTN_NONE;
                dec.mod     = MOD_TMO_KEY;
            end
            3'd1:
            begin
                if (byte0 == CH_CR)
                begin
                    dec.set_btn = 1'b1;
                    dec.btn     = BTN_ENTER;
                    dec.mod     = MOD_BTN;
                end
                else if (byte0 == CH_DEL)
                begin
                    dec.set_btn = 1'b1;
                    dec.btn     = BTN_BACKSPACE;
                    dec.mod     = MOD_BTN;
                end
                else if (byte0 == CH_ESC)
                begin
                    dec.set_btn = 1'b1;
                    dec.btn     = BTN_ESC;
                    dec.mod     = MOD_BTN;
                end
                else if (byte0 < CH_SPACE)
                begin
                    dec.chr = byte0 + CTRL_BIAS;
                    dec.mod = MOD_CTRL;
                end
                else if (byte0 <= CH_TILDE)
                begin
                    dec.chr = byte0;
                    dec.mod = MOD_CHAR;
                end
            end
            3'd2:
            begin
                if (byte0 == CH_ESC && byte1 != 8'd0)
                begin
                    dec.chr = byte1;
                    dec.mod = MOD_ALT;
                end
            end
            3'd3:
            begin
                if (csi)
                begin
                    dec.mod     = MOD_BTN;
                    dec.set_btn = 1'b1;
                    unique case (byte2)
                        CH_UP_A: dec.btn = BTN_UP;
                        CH_UP_B: dec.btn = BTN_DOWN;
                        CH_UP_C: dec.btn = BTN_RIGHT;
                        CH_UP_D: dec.btn = BTN_LEFT;
                        CH_UP_H: dec.btn = BTN_HOME;
                        CH_UP_F: dec.btn = BTN_END;
                        default: dec.ok  = 1'b0;
                    endcase
                end
            end
            3'd4:
            begin
                if (csi && byte3 == CH_TILDE)
                begin
                    dec.mod     = MOD_BTN;
                    dec.set_btn = 1'b1;
                    if (byte2 == CH_FIVE)
                        dec.btn = BTN_PGUP;
                    else if (byte2 == CH_SIX)
                        dec.btn = BTN_PGDN;
                    else
                        dec.ok = 1'b0;
                end
            end
            3'd6:
            begin
                if (csi && byte2 == CH_ONE && byte3 == CH_SEMI)
                begin
                    dec.mod = MOD_BTN;
                    if (byte5 < CH_UP_A || byte5 > CH_UP_D)
                        dec.ok = 1'b0;
                    if (byte4 >= CH_TWO && byte4 <= CH_SIX)
                    begin
                        dec.set_btn = 1'b1;
                        dec.btn     = BTN_MOD_BASE + {1'b0, dir, 2'b00} + {3'b000, dir}
                                      + {2'b00, digit};
                    end
                end
            end
            default:
            begin
                dec.ok = 1'b0;
            end
        endcase
    end

endmodule

// ----- rtl/tkd_hold.sv -----
`timescale 1ns / 1ps

module tkd_hold
#(
    parameter int MAX_REPEAT = 3
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  tkd_pkg::dec_t dec,
    output tkd_pkg::res_t res
);
    import tkd_pkg::*;

    logic [4:0] last_button_reg, last_button_next;
    logic [7:0] held_char_reg,   held_char_next;
    logic [4:0] held_button_reg, held_button_next;
    logic [5:0] held_mod_reg,    held_mod_next;
    logic [3:0] held_count_reg,  held_count_next;
    logic       commit_next;
    logic       idle;
    logic       rpt_key;
    logic [4:0] cnt_inc;

    assign last_button_next = dec.set_btn ? dec.btn : last_button_reg;
    assign idle    = (held_mod_reg == MOD_TMO_KEY || held_mod_reg == '0)
                     && held_button_reg == BTN_NONE;
    assign rpt_key = |(dec.mod & MOD_REPEAT);
    assign cnt_inc = {1'b0, held_count_reg} + 5'd1;

    always_comb
    begin
        held_char_next   = held_char_reg;
        held_button_next = held_button_reg;
        held_mod_next    = held_mod_reg;
        held_count_next  = held_count_reg;
        commit_next      = 1'b0;
        if (idle)
        begin
            if (dec.mod != '0)
            begin
                held_mod_next    = dec.mod;
                held_char_next   = dec.chr;
                held_button_next = last_button_next;
                held_count_next  = 4'd1;
                commit_next      = !rpt_key;
            end
        end
        else if (dec.mod == MOD_TMO_KEY && last_button_next == BTN_NONE)
        begin
            commit_next = 1'b1;
        end
        else if (rpt_key && dec.chr == held_char_reg)
        begin
            if (cnt_inc == 5'(MAX_REPEAT))
            begin
                commit_next     = 1'b1;
                held_count_next = cnt_inc[3:0];
            end
            else if (cnt_inc < 5'(MAX_REPEAT))
            begin
                held_count_next = cnt_inc[3:0];
            end
        end
        else
        begin
            held_mod_next    = dec.mod;
            held_char_next   = dec.chr;
            held_button_next = last_button_next;
            held_count_next  = 4'd1;
            commit_next      = !rpt_key;
        end
    end

    always_comb
    begin
        res = '0;
        if (dec.ok)
        begin
            res.ok           = 1'b1;
            res.key_mod      = held_mod_next;
            res.key_char     = held_char_next;
            res.key_button   = held_button_next;
            res.repeat_count = held_count_next;
            res.committed    = commit_next;
            res.is_timeout   = held_button_next == BTN_NONE && held_mod_next == MOD_TMO_KEY;
            res.is_text_key  = held_mod_next == MOD_CHAR && held_count_next == 4'd1
                               && commit_next;
            res.is_backspace = held_button_next == BTN_BACKSPACE && held_mod_next == MOD_BTN
                               && commit_next;
        end
    end

    // committed key clears right after it is reported
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_button_reg <= '0;
            held_char_reg   <= '0;
            held_button_reg <= '0;
            held_mod_reg    <= '0;
            held_count_reg  <= '0;
        end
        else if (en && dec.ok)
        begin
            last_button_reg <= last_button_next;
            if (commit_next)
            begin
                held_char_reg   <= '0;
                held_button_reg <= '0;
                held_mod_reg    <= '0;
                held_count_reg  <= '0;
            end
            else
            begin
                held_char_reg   <= held_char_next;
                held_button_reg <= held_button_next;
                held_mod_reg    <= held_mod_next;
                held_count_reg  <= held_count_next;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, held_count_reg} <= 5'(MAX_REPEAT))
        else $error("held count above limit");

    a_mod_count: assert property (@(posedge clk) disable iff (!rst_n)
        (held_mod_reg != '0) == (held_count_reg != '0))
        else $error("held flags and count disagree");

    a_commit_clear: assert property (@(posedge clk) disable iff (!rst_n)
        en && res.committed |=> held_mod_reg == '0 && held_count_reg == '0
                                && held_button_reg == '0)
        else $error("committed key not cleared");
`endif

endmodule

// ----- rtl/terminal_key_sequence_decoder.sv -----
`timescale 1ns / 1ps

// Path: input register, then result register.
// Throughput: one beat per cycle unless the result side stalls; decode and held-key update are combinational.
// Backpressure on the result side stalls the input register in place.
// Reset (rst_n low, async): pipeline empty, held key, repeat count and last button cleared.
module terminal_key_sequence_decoder
#(
    parameter int MAX_REPEAT = 3
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // read_failed, byte_count[2:0], byte0..byte5, zero pad
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // ok, key_mod[5:0], key_char[7:0], key_button[4:0], repeat_count[3:0],
    // committed, is_timeout, is_text_key, is_backspace, zero pad
    output logic [31:0] m_axis_tdata
);
    import tkd_pkg::*;

    logic        in_valid_reg;
    logic [55:0] in_data_reg;
    logic        out_valid_reg;
    logic [31:0] out_data_reg;
    logic        out_adv;
    logic        stage_en;
    dec_t        dec;
    res_t        res;

    assign out_adv       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || out_adv;
    assign stage_en      = in_valid_reg && out_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_data_reg <= s_axis_tdata;
        end
    end

    tkd_decode u_decode
    (
        .byte_count (in_data_reg[3:1]),
        .byte0      (in_data_reg[11:4]),
        .byte1      (in_data_reg[19:12]),
        .byte2      (in_data_reg[27:20]),
        .byte3      (in_data_reg[35:28]),
        .byte4      (in_data_reg[43:36]),
        .byte5      (in_data_reg[51:44]),
        .dec        (dec)
    );

    dec_t dec_gated;

    // failed read overrides the decode
    always_comb
    begin
        dec_gated = dec;
        if (in_data_reg[0])
            dec_gated.ok = 1'b0;
    end

    tkd_hold #(.MAX_REPEAT(MAX_REPEAT)) u_hold
    (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (stage_en),
        .dec   (dec_gated),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_adv)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en)
        begin
            out_data_reg <= {4'b0000, res.is_backspace, res.is_text_key, res.is_timeout,
                             res.committed, res.repeat_count, res.key_button, res.key_char,
                             res.key_mod, res.ok};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef NO_ASSERTIONS
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[31:1] == '0)
        else $error("failed beat carries nonzero fields");

    a_text_commit: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[26] |-> m_axis_tdata[24] && m_axis_tdata[23:20] == 4'd1)
        else $error("text key flag without single committed key");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !out_adv |=> in_valid_reg && $stable(in_data_reg))
        else $error("input stage lost a stalled beat");
`endif

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;

    import tkd_pkg::*;

    localparam int MAX_REPEAT  = 3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int ERR_PRINTS  = 40;

    // one terminal read, read_failed in bit 0
    typedef struct packed {
        logic [7:0] b5;
        logic [7:0] b4;
        logic [7:0] b3;
        logic [7:0] b2;
        logic [7:0] b1;
        logic [7:0] b0;
        logic [2:0] cnt;
        logic       failed;
    } read_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;

    // decoder state mirror
    logic [4:0] last_btn;
    logic [7:0] held_chr;
    logic [4:0] held_btn;
    logic [5:0] held_mod;
    logic [3:0] held_cnt;
    logic       held_commit;

    res_t expected_keys[$];

    int tx_idle_pct;
    int rx_idle_pct;
    int rx_hold;
    int cycles;
    int errors;
    int n_sent;
    int n_checked;
    int n_rejected;
    int n_repeat_commits;
    int n_text_keys;

    terminal_key_sequence_decoder #(
        .MAX_REPEAT (MAX_REPEAT)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever
        begin
            #4 clk = ~clk;
        end
    end

    function automatic void clear_held();
        held_chr    = '0;
        held_btn    = BTN_NONE;
        held_mod    = '0;
        held_cnt    = '0;
        held_commit = 1'b0;
    endfunction

    function automatic void load_held(logic [5:0] km, logic [7:0] kc, logic [4:0] kb);
        held_mod = km;
        held_chr = kc;
        held_btn = kb;
        held_cnt = 4'd1;
    endfunction

    // decode one read, update the held key, return the reported key
    function automatic res_t predict_key(read_t rd);
        logic [5:0] km;
        logic [7:0] kc;
        logic [4:0] kb;
        logic       good;
        int         nxt;
        res_t       r;
        r    = '0;
        km   = '0;
        kc   = '0;
        kb   = last_btn;
        good = !rd.failed;
        if (good)
        begin
            case (rd.cnt)
                3'd0:
                begin
                    kb = BTN_NONE;
                    km = MOD_TMO_KEY;
                end
                3'd1:
                begin
                    if (rd.b0 == CH_CR)
                    begin
                        kb = BTN_ENTER;
                        km = MOD_BTN;
                    end
                    else if (rd.b0 == CH_DEL)
                    begin
                        kb = BTN_BACKSPACE;
                        km = MOD_BTN;
                    end
                    else if (rd.b0 == CH_ESC)
                    begin
                        kb = BTN_ESC;
                        km = MOD_BTN;
                    end
                    else if (rd.b0 < CH_SPACE)
                    begin
                        kc = rd.b0 + CTRL_BIAS;
                        km = MOD_CTRL;
                    end
                    else if (rd.b0 <= CH_TILDE)
                    begin
                        kc = rd.b0;
                        km = MOD_CHAR;
                    end
                end
                3'd2:
                begin
                    if (rd.b0 == CH_ESC && rd.b1 != 8'd0)
                    begin
                        kc = rd.b1;
                        km = MOD_ALT;
                    end
                end
                3'd3:
                begin
                    if (rd.b0 == CH_ESC && rd.b1 == CH_CSI)
                    begin
                        km = MOD_BTN;
                        case (rd.b2)
                            CH_UP_A: kb = BTN_UP;
                            CH_UP_B: kb = BTN_DOWN;
                            CH_UP_C: kb = BTN_RIGHT;
                            CH_UP_D: kb = BTN_LEFT;
                            CH_UP_H: kb = BTN_HOME;
                            CH_UP_F: kb = BTN_END;
                            default: good = 1'b0;
                        endcase
                    end
                end
                3'd4:
                begin
                    if (rd.b0 == CH_ESC && rd.b1 == CH_CSI && rd.b3 == CH_TILDE)
                    begin
                        km = MOD_BTN;
                        if (rd.b2 == CH_FIVE)
                            kb = BTN_PGUP;
                        else if (rd.b2 == CH_SIX)
                            kb = BTN_PGDN;
                        else
                            good = 1'b0;
                    end
                end
                3'd6:
                begin
                    if (rd.b0 == CH_ESC && rd.b1 == CH_CSI && rd.b2 == CH_ONE
                        && rd.b3 == CH_SEMI)
                    begin
                        km = MOD_BTN;
                        if (rd.b5 < CH_UP_A || rd.b5 > CH_UP_D)
                            good = 1'b0;
                        else if (rd.b4 >= CH_TWO && rd.b4 <= CH_SIX)
                            kb = BTN_MOD_BASE + 5'(5 * (rd.b5 - CH_UP_A))
                                 + 5'(rd.b4 - CH_TWO);
                    end
                end
                default: good = 1'b0;
            endcase
        end
        if (!good)
            return r;
        last_btn = kb;

        if ((held_mod == MOD_TMO_KEY || held_mod == 6'd0) && held_btn == BTN_NONE)
        begin
            if (km != 6'd0)
            begin
                load_held(km, kc, kb);
                held_commit = (km == MOD_CHAR) || ((km & MOD_REPEAT) == 6'd0);
            end
        end
        else if (km == MOD_TMO_KEY && kb == BTN_NONE)
            held_commit = 1'b1;
        else if ((km & MOD_REPEAT) != 6'd0 && kc == held_chr)
        begin
            nxt = int'(held_cnt) + 1;
            if (nxt <= MAX_REPEAT)
            begin
                held_commit = (nxt == MAX_REPEAT);
                held_cnt    = 4'(nxt);
            end
        end
        else
        begin
            load_held(km, kc, kb);
            held_commit = ((km & MOD_REPEAT) == 6'd0);
        end

        r.ok           = 1'b1;
        r.key_mod      = held_mod;
        r.key_char     = held_chr;
        r.key_button   = held_btn;
        r.repeat_count = held_cnt;
        r.committed    = held_commit;
        r.is_timeout   = (held_btn == BTN_NONE && held_mod == MOD_TMO_KEY);
        r.is_text_key  = (held_mod == MOD_CHAR && held_cnt == 4'd1 && held_commit);
        r.is_backspace = (held_btn == BTN_BACKSPACE && held_mod == MOD_BTN && held_commit);
        if (held_commit)
            clear_held();
        return r;
    endfunction

    task automatic flag_error(string msg);
        errors++;
        if (errors <= ERR_PRINTS)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    task automatic check_field(string name, int got, int want);
        if (got != want)
            flag_error($sformatf("key %0d %s got %0d expected %0d", n_checked, name, got,
                                 want));
    endtask

    // called at a rising edge; returns at the edge that accepts the beat
    task automatic send_read(read_t rd);
        res_t r;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, rd};
        @(negedge clk);
        while (!s_axis_tready)
            @(negedge clk);
        @(posedge clk);
        r = predict_key(rd);
        expected_keys.push_back(r);
        n_sent++;
        if (!r.ok)
            n_rejected++;
        if (r.committed && r.repeat_count == 4'(MAX_REPEAT))
            n_repeat_commits++;
        if (r.is_text_key)
            n_text_keys++;
    endtask

    function automatic read_t key_read(int n, logic [7:0] c0 = 0, logic [7:0] c1 = 0,
                                       logic [7:0] c2 = 0, logic [7:0] c3 = 0,
                                       logic [7:0] c4 = 0, logic [7:0] c5 = 0);
        read_t rd;
        rd.failed = 1'b0;
        rd.cnt    = 3'(n);
        rd.b0     = c0;
        rd.b1     = c1;
        rd.b2     = c2;
        rd.b3     = c3;
        rd.b4     = c4;
        rd.b5     = c5;
        return rd;
    endfunction

    function automatic logic [7:0] arrow_final();
        case ($urandom_range(3))
            0: return CH_UP_A;
            1: return CH_UP_B;
            2: return CH_UP_C;
            default: return CH_UP_D;
        endcase
    endfunction

    // mostly well formed sequences, garbage in the unused bytes
    function automatic read_t random_read();
        logic [63:0] raw;
        read_t       rd;
        int          sel;
        raw       = {$urandom, $urandom};
        rd        = raw[51:0];
        rd.failed = 1'b0;
        sel       = $urandom_range(99);
        if (sel < 6)
            rd.cnt = 3'd0;
        else if (sel < 30)
        begin
            rd.cnt = 3'd1;
            case ($urandom_range(5))
                0:
                begin
                    case ($urandom_range(2))
                        0: rd.b0 = CH_CR;
                        1: rd.b0 = CH_DEL;
                        default: rd.b0 = CH_ESC;
                    endcase
                end
                1, 2: rd.b0 = 8'($urandom_range(31));
                3, 4: rd.b0 = 8'($urandom_range(32, 126));
                default: rd.b0 = 8'($urandom_range(127, 255));
            endcase
        end
        else if (sel < 44)
        begin
            rd.cnt = 3'd2;
            if ($urandom_range(4) != 0)
                rd.b0 = CH_ESC;
            if ($urandom_range(7) == 0)
                rd.b1 = 8'd0;
        end
        else if (sel < 56)
        begin
            rd.cnt = 3'd3;
            if ($urandom_range(7) != 0)
            begin
                rd.b0 = CH_ESC;
                rd.b1 = CH_CSI;
            end
            case ($urandom_range(3))
                0: rd.b2 = CH_UP_H;
                1: rd.b2 = CH_UP_F;
                2: rd.b2 = arrow_final();
                default: ;
            endcase
        end
        else if (sel < 66)
        begin
            rd.cnt = 3'd4;
            if ($urandom_range(7) != 0)
            begin
                rd.b0 = CH_ESC;
                rd.b1 = CH_CSI;
            end
            if ($urandom_range(5) != 0)
                rd.b3 = CH_TILDE;
            if ($urandom_range(4) != 0)
                rd.b2 = $urandom_range(1) ? CH_FIVE : CH_SIX;
        end
        else if (sel < 84)
        begin
            rd.cnt = 3'd6;
            if ($urandom_range(9) != 0)
            begin
                rd.b0 = CH_ESC;
                rd.b1 = CH_CSI;
                rd.b2 = CH_ONE;
                rd.b3 = CH_SEMI;
            end
            if ($urandom_range(5) != 0)
                rd.b4 = 8'($urandom_range(CH_TWO, CH_SIX));
            if ($urandom_range(5) != 0)
                rd.b5 = arrow_final();
        end
        else if (sel < 90)
            rd.cnt = $urandom_range(1) ? 3'd5 : 3'd7;
        else if (sel < 95)
            rd.failed = 1'b1;
        else
            rd.failed = raw[63];
        return rd;
    endfunction

    // a control or Alt key with a small character set, so repeats line up
    function automatic read_t repeat_key();
        if ($urandom_range(1))
            return key_read(1, 8'($urandom_range(1, 3)));
        return key_read(2, CH_ESC, 8'($urandom_range(97, 99)));
    endfunction

    task automatic test_plain_keys();
        send_read(key_read(0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_read(key_read(1, CH_CR));
        send_read(key_read(1, CH_DEL));
        send_read(key_read(1, CH_ESC));
        send_read(key_read(1, CH_SPACE));
        send_read(key_read(1, CH_TILDE));
        send_read(key_read(1, 8'hFF));
        send_read(key_read(1, 8'h00));
        send_read(key_read(1, 8'h00));
        send_read(key_read(1, 8'h00));
        send_read(key_read(1, 8'h00));
    endtask

    task automatic test_alt_and_timeout();
        send_read(key_read(2, CH_ESC, 8'hFF));
        send_read(key_read(2, CH_ESC, 8'hFF));
        send_read(key_read(0));
        send_read(key_read(2, CH_ESC, 8'h00));
        send_read(key_read(1, 8'h1F));
        send_read(key_read(2, 8'h00, 8'h00));
    endtask

    task automatic test_cursor_keys();
        send_read(key_read(3, CH_ESC, CH_CSI, CH_UP_H));
        send_read(key_read(3, CH_ESC, CH_CSI, CH_UP_D));
        send_read(key_read(3, CH_ESC, CH_CSI, 8'h5A));
        send_read(key_read(4, CH_ESC, CH_CSI, CH_FIVE, CH_TILDE));
        send_read(key_read(4, CH_ESC, CH_CSI, 8'h37, CH_TILDE));
        send_read(key_read(6, CH_ESC, CH_CSI, CH_ONE, CH_SEMI, CH_SIX, CH_UP_D));
        // unknown modifier digit keeps the previous button
        send_read(key_read(6, CH_ESC, CH_CSI, CH_ONE, CH_SEMI, 8'h39, CH_UP_A));
        send_read(key_read(6, CH_ESC, CH_CSI, CH_ONE, CH_SEMI, CH_TWO, 8'h45));
    endtask

    task automatic test_rejected_reads();
        read_t rd;
        rd        = key_read(1, CH_CR);
        rd.failed = 1'b1;
        send_read(rd);
        send_read(key_read(5, CH_ESC, CH_CSI, CH_ONE, CH_SEMI, CH_TWO));
        send_read(key_read(7, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    endtask

    task automatic test_random_reads(int n, int tx_pct, int rx_pct);
        int    stop;
        int    reps;
        read_t rd;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        stop        = n_sent + n;
        while (n_sent < stop)
        begin
            if ($urandom_range(3) == 0)
            begin
                rd   = repeat_key();
                reps = $urandom_range(2, 5);
                repeat (reps) send_read(rd);
            end
            else
                send_read(random_read());
        end
    endtask

    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold     = 80;
        repeat (120) send_read(random_read());
    endtask

    // receiver
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rx_hold > 0)
            begin
                m_axis_tready <= 1'b0;
                rx_hold--;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // result checker, sampled mid-cycle ahead of the accepting edge
    initial
    begin
        res_t got;
        res_t want;
        forever
        begin
            @(negedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                got.ok           = m_axis_tdata[0];
                got.key_mod      = m_axis_tdata[6:1];
                got.key_char     = m_axis_tdata[14:7];
                got.key_button   = m_axis_tdata[19:15];
                got.repeat_count = m_axis_tdata[23:20];
                got.committed    = m_axis_tdata[24];
                got.is_timeout   = m_axis_tdata[25];
                got.is_text_key  = m_axis_tdata[26];
                got.is_backspace = m_axis_tdata[27];
                if (expected_keys.size() == 0)
                    flag_error($sformatf("unexpected result beat 0x%08h", m_axis_tdata));
                else
                begin
                    want = expected_keys.pop_front();
                    check_field("ok", got.ok, want.ok);
                    check_field("key_mod", got.key_mod, want.key_mod);
                    check_field("key_char", got.key_char, want.key_char);
                    check_field("key_button", got.key_button, want.key_button);
                    check_field("repeat_count", got.repeat_count, want.repeat_count);
                    check_field("committed", got.committed, want.committed);
                    check_field("is_timeout", got.is_timeout, want.is_timeout);
                    check_field("is_text_key", got.is_text_key, want.is_text_key);
                    check_field("is_backspace", got.is_backspace, want.is_backspace);
                    n_checked++;
                end
            end
        end
    end

    // watchdog
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles, %0d results outstanding", cycles,
                         expected_keys.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        int drain;
        last_btn         = BTN_NONE;
        clear_held();
        tx_idle_pct      = 0;
        rx_idle_pct      = 0;
        rx_hold          = 0;
        errors           = 0;
        n_sent           = 0;
        n_checked        = 0;
        n_rejected       = 0;
        n_repeat_commits = 0;
        n_text_keys      = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 27;
        rx_idle_pct = 67;
        test_plain_keys();
        test_alt_and_timeout();
        test_cursor_keys();
        test_rejected_reads();

        test_random_reads(600, 27, 67);
        test_random_reads(600, 67, 27);
        test_backpressure();
        test_random_reads(600, 0, 0);
        s_axis_tvalid <= 1'b0;

        while (expected_keys.size() != 0)
            @(posedge clk);
        drain = 0;
        while (drain < 10)
        begin
            @(posedge clk);
            drain++;
        end

        $display("%0d reads sent, %0d results checked: %0d rejected, %0d repeat commits, %0d text keys",
                 n_sent, n_checked, n_rejected, n_repeat_commits, n_text_keys);
        $display("covered timeouts, buttons, control, Alt, text, cursor and modified arrows under stalls");
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/tkd_pkg.sv
rtl/tkd_decode.sv
rtl/tkd_hold.sv
rtl/terminal_key_sequence_decoder.sv
dv/tb.sv
